>>> hw/rtl/bvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types and constants of the battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int ADC_W       = 12;
    localparam int GAIN_W      = 20;
    localparam int MV_W        = 15;
    localparam int PCT_W       = 7;
    localparam int SCALE_W     = 16;
    localparam int FILT_W      = 23;
    localparam int FX_W        = 27;
    localparam int PCT_DIFF_W  = 12;
    localparam int PCT_PROD_W  = 25;
    localparam int FILT_PROD_W = 55;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam int QUEUE_DEPTH = 2;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_MV_PER_COUNT = 2'd0;
    localparam logic [1:0] REG_LOW_THR      = 2'd1;
    localparam logic [1:0] REG_HIGH_THR     = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = 20'd316880;
    localparam logic [MV_W-1:0]   LOW_THR_RESET  = 15'd11000;
    localparam logic [MV_W-1:0]   HIGH_THR_RESET = 15'd14400;

    localparam logic [MV_W-1:0] VMAX_MV      = 15'd24000;
    localparam logic [MV_W-1:0] PCT_EMPTY_MV = 15'd11000;
    localparam logic [MV_W-1:0] PCT_FULL_MV  = 15'd14400;
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;

    // floor(d / 34) for d < 4096: d * ceil(2^18 / 34) >> 18
    localparam logic [12:0] PCT_RECIP = 13'd7711;
    localparam int          PCT_SHIFT = 18;

    // floor(x / 10) for x < 2^27: x * ceil(2^31 / 10) >> 31
    localparam logic [27:0] FILT_RECIP = 28'd214748365;
    localparam int          FILT_SHIFT = 31;

    typedef enum logic [1:0] {
        LVL_LOW    = 2'd0,
        LVL_NORMAL = 2'd1,
        LVL_HIGH   = 2'd2
    } t_level;

    typedef struct packed {
        logic [ADC_W-1:0] sample;
        logic             first;
        logic             zero;
    } t_item;

    typedef struct packed {
        logic [GAIN_W-1:0] mv_per_count_q16;
        logic [MV_W-1:0]   low_threshold_mv;
        logic [MV_W-1:0]   high_threshold_mv;
    } t_cfg;

endpackage

>>> hw/rtl/bvm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bvm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/bvm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_front
// Accepts sample words, tags the first one and failed conversions, and
// holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bvm_front import bvm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [ADC_W-1:0] i_adc_sample,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  logic             i_q_pop
);

    t_item      r_slot [QUEUE_DEPTH];
    logic       r_wr_sel, n_wr_sel;
    logic       r_rd_sel, n_rd_sel;
    logic [1:0] r_count,  n_count;
    logic       r_seen,   n_seen;
    logic       accept;
    t_item      n_item;

    assign o_in_stall = (r_count == 2'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_slot[r_rd_sel];

    always_comb begin
        n_item.sample = i_adc_sample;
        n_item.first  = !r_seen;
        n_item.zero   = (i_adc_sample == '0);

        n_wr_sel = accept  ? !r_wr_sel : r_wr_sel;
        n_rd_sel = i_q_pop ? !r_rd_sel : r_rd_sel;
        n_seen   = r_seen || accept;
        case ({accept, i_q_pop})
            2'b10: begin
                n_count = r_count + 2'd1;
            end
            2'b01: begin
                n_count = r_count - 2'd1;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_sel <= 1'b0;
            r_rd_sel <= 1'b0;
            r_count  <= 2'd0;
            r_seen   <= 1'b0;
        end else begin
            r_wr_sel <= n_wr_sel;
            r_rd_sel <= n_rd_sel;
            r_count  <= n_count;
            r_seen   <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wr_sel] <= n_item;
        end
    end

endmodule

>>> hw/rtl/bvm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_back
// Window update, averaging, scaling, status, percent and IIR filter,
// sequenced by a state machine one word at a time, with an output register.
// ----------------------------------------------------------------------------
module bvm_back import bvm_pkg::*; #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [MV_W-1:0]  o_avg_mv,
    output logic [1:0]       o_level_status,
    output logic [PCT_W-1:0] o_charge_pct,
    output logic [MV_W-1:0]  o_smoothed_mv
);

    localparam int PW        = $clog2(WINDOW_DEPTH);
    localparam int SW        = ADC_W + PW;
    localparam int RW        = SW + 2;
    localparam int AVG_SHIFT = SW + PW;
    localparam int AP_W      = SW + RW;
    localparam logic [63:0] AVG_RECIP_FULL =
        ((64'd1 << AVG_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [RW-1:0] AVG_RECIP = AVG_RECIP_FULL[RW-1:0];
    localparam logic [PW-1:0] LAST_PTR  = PW'(WINDOW_DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ACC   = 6'b000010,
        ST_AVG   = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_wptr, n_wptr;
    logic              r_wrapped, n_wrapped;
    logic [SW-1:0]     r_sum, n_sum;
    logic [ADC_W-1:0]  r_seed, n_seed;
    logic [FILT_W-1:0] r_filt, n_filt;
    logic              r_out_valid, n_out_valid;

    t_item             r_item;
    logic [ADC_W-1:0]  r_avg;
    logic [SCALE_W-1:0] r_scaled;
    logic [MV_W-1:0]   r_mv, n_mv;
    t_level            r_status, n_status;
    logic              r_pct_zero, r_pct_full;
    logic [PCT_DIFF_W-1:0] r_pct_diff;
    logic [FX_W-1:0]   r_fx;
    logic [MV_W-1:0]   r_out_mv;
    t_level            r_out_status;
    logic [PCT_W-1:0]  r_out_pct, n_pct;
    logic [MV_W-1:0]   r_out_smooth;

    logic [ADC_W-1:0]  ram_rdata;
    logic              ram_we;
    logic [ADC_W-1:0]  old_sample;
    logic [SW-1:0]     sum_base;
    logic [AP_W-1:0]   avg_prod;
    logic [PCT_PROD_W-1:0]  pct_prod;
    logic [FILT_PROD_W-1:0] filt_prod;
    logic              load;

    bvm_ram #(
        .WIDTH (ADC_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (r_item.sample),
        .i_raddr (r_wptr),
        .o_rdata (ram_rdata)
    );

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign load    = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);
    assign ram_we  = (r_state == ST_ACC) && !r_item.zero;

    // entries not yet written since the first word read as its value, kept in r_seed
    assign old_sample = r_item.first ? r_item.sample : (r_wrapped ? ram_rdata : r_seed);
    assign sum_base   = r_item.first ? SW'(r_item.sample) * SW'(WINDOW_DEPTH) : r_sum;

    assign avg_prod  = AP_W'(r_sum) * AP_W'(AVG_RECIP);
    assign pct_prod  = PCT_PROD_W'(r_pct_diff) * PCT_PROD_W'(PCT_RECIP);
    assign filt_prod = FILT_PROD_W'(r_fx) * FILT_PROD_W'(FILT_RECIP);

    always_comb begin
        n_state     = r_state;
        n_wptr      = r_wptr;
        n_wrapped   = r_wrapped;
        n_sum       = r_sum;
        n_seed      = r_seed;
        n_filt      = r_filt;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (r_item.first) begin
                    n_seed = r_item.sample;
                end
                n_sum = sum_base;
                if (!r_item.zero) begin
                    n_sum  = sum_base - SW'(old_sample) + SW'(r_item.sample);
                    n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
                    if (r_wptr == LAST_PTR) begin
                        n_wrapped = 1'b1;
                    end
                end
                n_state = ST_AVG;
            end
            ST_AVG: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (load) begin
                    n_filt      = r_item.first ? (FILT_W'(r_mv) << 8)
                                               : FILT_W'(filt_prod >> FILT_SHIFT);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_mv = (r_scaled > SCALE_W'(VMAX_MV)) ? VMAX_MV : r_scaled[MV_W-1:0];
        if (n_mv < i_cfg.low_threshold_mv) begin
            n_status = LVL_LOW;
        end else if (n_mv > i_cfg.high_threshold_mv) begin
            n_status = LVL_HIGH;
        end else begin
            n_status = LVL_NORMAL;
        end

        if (r_pct_zero) begin
            n_pct = '0;
        end else if (r_pct_full) begin
            n_pct = PCT_MAX;
        end else begin
            n_pct = PCT_W'(pct_prod >> PCT_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wptr      <= '0;
            r_wrapped   <= 1'b0;
            r_sum       <= '0;
            r_seed      <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_wrapped   <= n_wrapped;
            r_sum       <= n_sum;
            r_seed      <= n_seed;
            r_filt      <= n_filt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state == ST_AVG) begin
            r_avg <= avg_prod[AVG_SHIFT +: ADC_W];
        end
        if (r_state == ST_SCALE) begin
            r_scaled <= SCALE_W'((32'(r_avg) * 32'(i_cfg.mv_per_count_q16)) >> 16);
        end
        if (r_state == ST_EVAL) begin
            r_mv       <= n_mv;
            r_status   <= n_status;
            r_pct_zero <= (n_mv <= PCT_EMPTY_MV);
            r_pct_full <= (n_mv >= PCT_FULL_MV);
            r_pct_diff <= PCT_DIFF_W'(n_mv - PCT_EMPTY_MV);
            r_fx       <= (FX_W'(r_filt) << 3) + FX_W'(r_filt) + (FX_W'(n_mv) << 8);
        end
        if (load) begin
            r_out_mv     <= r_mv;
            r_out_status <= r_status;
            r_out_pct    <= n_pct;
            r_out_smooth <= n_filt[FILT_W-1:8];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_avg_mv       = r_out_mv;
    assign o_level_status = r_out_status;
    assign o_charge_pct   = r_out_pct;
    assign o_smoothed_mv  = r_out_smooth;

endmodule

>>> hw/rtl/battery_voltage_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_monitor_unit
// Averaging battery voltage monitor with status, percent and IIR outputs.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one 12-bit converter word;
// a zero word is a failed conversion and is not added to the window.
// Output channel: o_out_valid / i_out_stall carry one result word per input
// word: voltage in mV, low/normal/high status, percent and filtered mV.
// APB port: gain at 0x0, low threshold at 0x4, high threshold at 0x8;
// pready is always high. Write registers only while the block is idle.
// Sequencing: the back-end sequencer steps through six states per word
// (queue pop with window read, sum update, reciprocal divide, gain
// multiply, evaluate, output load) and pops the next word only after
// the output load of the last one, which waits while the result is held.
// Reset: window pointer, running sum, filter and queues clear; the first
// word after reset seeds the window and the filter. No clearing pass.
// Receiver stall: the result holds in the output register; the back end
// finishes the next word and waits, and the two-entry input queue fills
// before o_in_stall rises.
// ----------------------------------------------------------------------------
module battery_voltage_monitor_unit import bvm_pkg::*; #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADC_W-1:0]      i_adc_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [MV_W-1:0]       o_avg_mv,
    output logic [1:0]            o_level_status,
    output logic [PCT_W-1:0]      o_charge_pct,
    output logic [MV_W-1:0]       o_smoothed_mv,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg  r_cfg, n_cfg;
    logic  cfg_wr;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_MV_PER_COUNT: begin
                    n_cfg.mv_per_count_q16 = pwdata[GAIN_W-1:0];
                end
                REG_LOW_THR: begin
                    n_cfg.low_threshold_mv = pwdata[MV_W-1:0];
                end
                REG_HIGH_THR: begin
                    n_cfg.high_threshold_mv = pwdata[MV_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MV_PER_COUNT: begin
                prdata = APB_DATA_W'(r_cfg.mv_per_count_q16);
            end
            REG_LOW_THR: begin
                prdata = APB_DATA_W'(r_cfg.low_threshold_mv);
            end
            REG_HIGH_THR: begin
                prdata = APB_DATA_W'(r_cfg.high_threshold_mv);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mv_per_count_q16  <= GAIN_RESET;
            r_cfg.low_threshold_mv  <= LOW_THR_RESET;
            r_cfg.high_threshold_mv <= HIGH_THR_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    bvm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_adc_sample (i_adc_sample),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    bvm_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_avg_mv       (o_avg_mv),
        .o_level_status (o_level_status),
        .o_charge_pct   (o_charge_pct),
        .o_smoothed_mv  (o_smoothed_mv)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery voltage monitor. A short directed table
// and randomized runs of converter words go in under several gain and
// threshold settings. Each result word is checked against an in-bench model
// of the averaging window, scaling, status, percent and filter (typed table
// rows against their own values). Both sides idle at random, and the bench
// exercises one long receiver hold-off and full drains, one of them mid-run.
// ----------------------------------------------------------------------------
module tb;
    import bvm_pkg::*;

    localparam int WIN_LEN      = 8;
    localparam int ROW_COUNT    = 23;
    localparam int HOLD_CYCLES  = 400;
    localparam int WATCHDOG_MAX = 4000;
    localparam int SETTLE       = 12;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [MV_W-1:0]  mv;
        t_level           lvl;
        logic [PCT_W-1:0] pct;
        logic [MV_W-1:0]  filt;
    } t_reading;

    typedef struct packed {
        logic [ADC_W-1:0] sample;
        logic             typed;
        t_reading         want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [ADC_W-1:0]      i_adc_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [MV_W-1:0]       o_avg_mv;
    logic [1:0]            o_level_status;
    logic [PCT_W-1:0]      o_charge_pct;
    logic [MV_W-1:0]       o_smoothed_mv;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    battery_voltage_monitor_unit #(.WINDOW_DEPTH(WIN_LEN)) dut (.*);

    always #1 i_clk = ~i_clk;

    // model state and register shadows
    logic [ADC_W-1:0] win_samples [WIN_LEN];
    int               win_ptr = 0;
    int unsigned      win_sum = 0;
    bit               have_first = 1'b0;
    int unsigned      filt_q8 = 0;
    int unsigned      gain_q16 = 32'(GAIN_RESET);
    int unsigned      low_thr = 32'(LOW_THR_RESET);
    int unsigned      high_thr = 32'(HIGH_THR_RESET);

    t_reading pending_readings [$];
    int       fail_count = 0;
    bit       idle_on = 1'b1;
    bit       hold_req = 1'b0;
    bit       hold_seen = 1'b0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    // first word seeds the window; a zero word right after it is dropped
    t_row dir_rows [ROW_COUNT] = '{
        {12'd4095, 1'b1, 15'd19800, LVL_HIGH, 7'd100, 15'd19800},
        {12'd0,    1'b1, 15'd19800, LVL_HIGH, 7'd100, 15'd19800},
        {12'd1, 1'b0, 39'd0}, {12'd1, 1'b0, 39'd0}, {12'd1, 1'b0, 39'd0},
        {12'd1, 1'b0, 39'd0}, {12'd1, 1'b0, 39'd0}, {12'd1, 1'b0, 39'd0},
        {12'd1, 1'b0, 39'd0}, {12'd1, 1'b0, 39'd0},
        {12'd0, 1'b0, 39'd0}, {12'd2048, 1'b0, 39'd0},
        {12'd4095, 1'b0, 39'd0}, {12'd4095, 1'b0, 39'd0}, {12'd4095, 1'b0, 39'd0},
        {12'hAAA, 1'b0, 39'd0}, {12'h555, 1'b0, 39'd0},
        {12'd2500, 1'b0, 39'd0}, {12'd2600, 1'b0, 39'd0}, {12'd2700, 1'b0, 39'd0},
        {12'd2900, 1'b0, 39'd0}, {12'd3000, 1'b0, 39'd0}, {12'd1, 1'b0, 39'd0}
    };

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) note_fail($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function automatic t_reading predict_reading(logic [ADC_W-1:0] s);
        t_reading        r;
        longint unsigned prod;
        int unsigned     mv;
        int unsigned     pct;
        if (!have_first) begin
            for (int k = 0; k < WIN_LEN; k++) win_samples[k] = s;
            win_sum = int'(s) * WIN_LEN;
            win_ptr = 0;
        end
        if (s != 0) begin
            win_sum = win_sum - win_samples[win_ptr] + s;
            win_samples[win_ptr] = s;
            win_ptr = (win_ptr + 1) % WIN_LEN;
        end
        prod = (64'(win_sum / WIN_LEN) * 64'(gain_q16)) >> 16;
        mv = (prod > 64'(VMAX_MV)) ? 32'(VMAX_MV) : 32'(prod);
        // low wins when the thresholds cross
        if (mv < low_thr) r.lvl = LVL_LOW;
        else if (mv > high_thr) r.lvl = LVL_HIGH;
        else r.lvl = LVL_NORMAL;
        if (mv <= PCT_EMPTY_MV) pct = 0;
        else if (mv >= PCT_FULL_MV) pct = 32'(PCT_MAX);
        else pct = (mv - PCT_EMPTY_MV) * 100 / (PCT_FULL_MV - PCT_EMPTY_MV);
        if (!have_first) filt_q8 = mv << 8;
        else filt_q8 = (9 * filt_q8 + (mv << 8)) / 10;
        filt_q8 &= 32'h7FFFFF;
        have_first = 1'b1;
        r.mv = mv[MV_W-1:0];
        r.pct = pct[PCT_W-1:0];
        r.filt = filt_q8[22:8];
        return r;
    endfunction

    // aim the window at a voltage near the percent band most of the time
    function automatic int pick_center();
        int unsigned target;
        int unsigned c;
        if (gain_q16 == 0 || $urandom_range(99) < 40) return $urandom_range(4095, 1);
        target = $urandom_range(15000, 10500);
        c = (target << 16) / gain_q16;
        return (c < 1) ? 1 : (c > 4095) ? 4095 : c;
    endfunction

    function automatic logic [ADC_W-1:0] pick_sample(int center);
        int r;
        int v;
        int unsigned u;
        r = $urandom_range(99);
        if (r < 5) return '0;
        u = $urandom_range(4095);
        if (r < 30) return u[ADC_W-1:0];
        v = center + $urandom_range(128) - 64;
        return (v < 1) ? 12'd1 : (v > 4095) ? 12'd4095 : v[ADC_W-1:0];
    endfunction

    task automatic send_word(logic [ADC_W-1:0] s, logic typed, t_reading want);
        t_reading pred;
        while (idle_on && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_adc_sample <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = predict_reading(s);
        pending_readings.push_back(typed ? want : pred);
    endtask

    // stop offering and wait until every result word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_xfer(logic wr, logic [1:0] idx, logic [31:0] data,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(logic [1:0] idx, int unsigned want);
        logic [31:0] got;
        apb_xfer(1'b0, idx, '0, got);
        check_field($sformatf("register %0d", idx), want, got);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] unused;
        apb_xfer(1'b1, idx, value, unused);
        case (idx)
            REG_MV_PER_COUNT: begin
                gain_q16 = 32'(value[GAIN_W-1:0]);
                check_reg(idx, gain_q16);
            end
            REG_LOW_THR: begin
                low_thr = 32'(value[MV_W-1:0]);
                check_reg(idx, low_thr);
            end
            REG_HIGH_THR: begin
                high_thr = 32'(value[MV_W-1:0]);
                check_reg(idx, high_thr);
            end
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] gain, logic [31:0] lo, logic [31:0] hi);
        write_reg(REG_MV_PER_COUNT, gain);
        write_reg(REG_LOW_THR, lo);
        write_reg(REG_HIGH_THR, hi);
    endtask

    task automatic run_phase(int n_words, bit idle, bit hold, bit pause);
        int center;
        idle_on <= idle;
        center = pick_center();
        for (int k = 0; k < n_words; k++) begin
            if (k % 16 == 0) center = pick_center();
            // keep offering words while the receiver holds off
            if (hold && k == n_words / 3) hold_req <= ~hold_req;
            if (pause && k == n_words / 2) drain();
            send_word(pick_sample(center), 1'b0, '0);
        end
        drain();
    endtask

    // result side: check, then choose the next stall
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    note_fail("result word with nothing expected");
                end else begin
                    want = pending_readings.pop_front();
                    check_field("avg_mv", 32'(want.mv), 32'(o_avg_mv));
                    check_field("level_status", 32'(want.lvl), 32'(o_level_status));
                    check_field("charge_pct", 32'(want.pct), 32'(o_charge_pct));
                    check_field("smoothed_mv", 32'(want.filt), 32'(o_smoothed_mv));
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_on && ($urandom_range(99) < 13);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reg(REG_MV_PER_COUNT, 32'(GAIN_RESET));
        check_reg(REG_LOW_THR, 32'(LOW_THR_RESET));
        check_reg(REG_HIGH_THR, 32'(HIGH_THR_RESET));

        for (int r = 0; r < ROW_COUNT; r++)
            send_word(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].want);
        drain();

        // full gain with a wide normal band, no idling
        set_config(32'hFFFFF, 32'd0, 32'd24000);
        run_phase(200, 1'b0, 1'b0, 1'b0);
        // zero gain, both thresholds at the top
        set_config(32'd0, 32'd24000, 32'd24000);
        run_phase(200, 1'b1, 1'b1, 1'b0);
        // crossed thresholds
        set_config(32'(GAIN_RESET), 32'd14000, 32'd12000);
        run_phase(200, 1'b1, 1'b0, 1'b1);
        // all ones on every register, plus a write past the register list
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, $urandom);
        run_phase(150, 1'b1, 1'b0, 1'b0);

        for (int p = 0; p < 6; p++) begin
            set_config($urandom_range(420000, 200000), $urandom_range(24000),
                       $urandom_range(24000));
            run_phase(200, 1'b1, 1'b0, 1'b0);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> battery_voltage_monitor_unit.f
hw/rtl/bvm_pkg.sv
hw/rtl/bvm_ram.sv
hw/rtl/bvm_front.sv
hw/rtl/bvm_back.sv
hw/rtl/battery_voltage_monitor_unit.sv
tb/tb.sv
